>>> design/md5_pkg.sv
// Shared types and constants for the MD5 stream digest.
package md5_pkg;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hefcdab89;
    localparam logic [31:0] IV2 = 32'h98badcfe;
    localparam logic [31:0] IV3 = 32'h10325476;

    localparam int QUEUE_DEPTH = 4;

    localparam logic MODE_DATA   = 1'b0;
    localparam logic MODE_FINISH = 1'b1;

    typedef struct packed {
        logic       finish;
        logic [7:0] data;
    } t_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COMP,
        ST_PAD,
        ST_LEN,
        ST_EMIT
    } t_state;

    function automatic logic [31:0] round_k(input logic [5:0] r);
        logic [31:0] k;
        unique case (r)
            6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] round_s(input logic [5:0] r);
        logic [4:0] s;
        unique case ({r[5:4], r[1:0]})
            4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
            4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
        endcase
        return s;
    endfunction

    // message word index used in round r
    function automatic logic [3:0] round_g(input logic [5:0] r);
        logic [3:0] g;
        unique case (r[5:4])
            2'd0: g = r[3:0];
            2'd1: g = 4'(5 * r[3:0] + 1);
            2'd2: g = 4'(3 * r[3:0] + 5);
            default: g = 4'(7 * r[3:0]);
        endcase
        return g;
    endfunction

endpackage

>>> design/md5_front.sv
// Input front end: accepts transactions into a short queue.
module md5_front #(
    parameter int DEPTH = md5_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic          i_mode,
    input  logic [7:0]    i_data_byte,
    output logic          o_q_valid,
    output md5_pkg::t_item o_q_item,
    input  logic          i_q_pop
);
    import md5_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_item             r_mem [DEPTH];
    logic [AW-1:0]     r_wp, r_rp;
    logic [AW:0]       r_cnt;
    logic              push, pop;

    assign o_stall   = (r_cnt == (AW+1)'(DEPTH));
    assign push      = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != '0);
    assign pop       = i_q_pop && o_q_valid;
    assign o_q_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= '{finish: (i_mode == MODE_FINISH), data: i_data_byte};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (pop)  r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(DEPTH)) else $error("queue overflow");
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == (AW+1)'(DEPTH)) |-> o_stall) else $error("full without stall");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> (r_cnt != '0)) else $error("pop from empty");
endmodule

>>> design/md5_core.sv
// Back end: block buffer, padding sequencer, one-round-per-cycle compression, output.
module md5_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  md5_pkg::t_item i_q_item,
    output logic           o_q_pop,
    output logic           o_valid,
    input  logic           i_stall,
    output logic [31:0]    o_digest_word,
    output logic [1:0]     o_word_index,
    output logic           o_last_word
);
    import md5_pkg::*;

    t_state        r_state, n_state;
    logic [31:0]   r_w [16];  // block buffer as 16 little-endian words
    logic [5:0]    r_fill;
    logic [63:0]   r_len, r_len_snap;
    logic [31:0]   r_h [4];
    logic [31:0]   r_a, r_b, r_c, r_d;
    logic [5:0]    r_round;
    logic          r_after;   // return state after compression: 0 idle, 1 padding
    logic          r_final;   // set when the final (length) block is being compressed
    logic [2:0]    r_lcnt;
    logic [1:0]    r_widx;
    logic          r_ovalid;

    logic          wr_en;
    logic [7:0]    wr_byte;
    logic          q_pop;
    logic          start_comp;
    logic [31:0]   f, t, rot, wg;
    logic [3:0]    g;
    logic [4:0]    s;

    always_comb begin
        g = round_g(r_round);
        s = round_s(r_round);
        wg = r_w[g];
        unique case (r_round[5:4])
            2'd0: f = (r_b & r_c) | (~r_b & r_d);
            2'd1: f = (r_b & r_d) | (r_c & ~r_d);
            2'd2: f = r_b ^ r_c ^ r_d;
            default: f = r_c ^ (r_b | ~r_d);
        endcase
        t   = r_a + f + wg + round_k(r_round);
        rot = (t << s) | (t >> (6'd32 - {1'b0, s}));
    end

    always_comb begin
        n_state    = r_state;
        wr_en      = 1'b0;
        wr_byte    = 8'h00;
        q_pop      = 1'b0;
        start_comp = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    q_pop   = 1'b1;
                    wr_en   = 1'b1;
                    wr_byte = i_q_item.finish ? 8'h80 : i_q_item.data;
                    if (r_fill == 6'd63) begin
                        start_comp = 1'b1;
                        n_state    = ST_COMP;
                    end else if (i_q_item.finish) begin
                        n_state = (r_fill == 6'd55) ? ST_LEN : ST_PAD;
                    end
                end
            end
            ST_COMP: begin
                if (r_round == 6'd63) begin
                    if (r_final) begin
                        n_state = ST_EMIT;
                    end else begin
                        n_state = r_after ? ((r_fill == 6'd56) ? ST_LEN : ST_PAD) : ST_IDLE;
                    end
                end
            end
            ST_PAD: begin
                wr_en = 1'b1;
                if (r_fill == 6'd63) begin
                    start_comp = 1'b1;
                    n_state    = ST_COMP;
                end else if (r_fill == 6'd55) begin
                    n_state = ST_LEN;
                end
            end
            ST_LEN: begin
                wr_en   = 1'b1;
                wr_byte = r_len_snap[{r_lcnt, 3'd0} +: 8];
                if (r_lcnt == 3'd7) begin
                    start_comp = 1'b1;
                    n_state    = ST_COMP;
                end
            end
            ST_EMIT: begin
                if (r_widx == 2'd3 && !i_stall) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_q_pop       = q_pop;
    assign o_valid       = r_ovalid;
    assign o_digest_word = r_h[r_widx];
    assign o_word_index  = r_widx;
    assign o_last_word   = (r_widx == 2'd3);

    always_ff @(posedge i_clk) begin
        if (wr_en) r_w[r_fill[5:2]][{r_fill[1:0], 3'd0} +: 8] <= wr_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_fill   <= '0;
            r_len    <= '0;
            r_h[0]   <= IV0; r_h[1] <= IV1; r_h[2] <= IV2; r_h[3] <= IV3;
            r_round  <= '0;
            r_after  <= 1'b0;
            r_lcnt   <= '0;
            r_widx   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (wr_en) r_fill <= r_fill + 1'b1;
            if (q_pop) begin
                if (i_q_item.finish) begin
                    r_len_snap <= r_len;
                    r_after    <= 1'b1;
                end else begin
                    r_len   <= r_len + 64'd8;
                    r_after <= 1'b0;
                end
            end
            if (r_state == ST_LEN) r_lcnt <= r_lcnt + 1'b1;
            if (start_comp) begin
                r_a <= r_h[0]; r_b <= r_h[1]; r_c <= r_h[2]; r_d <= r_h[3];
                r_round <= '0;
                if (r_state == ST_LEN) r_after <= 1'b0;
            end
            if (r_state == ST_COMP) begin
                r_a <= r_d;
                r_d <= r_c;
                r_c <= r_b;
                r_b <= r_b + rot;
                r_round <= r_round + 1'b1;
                if (r_round == 6'd63) begin
                    r_h[0] <= r_h[0] + r_d;
                    r_h[1] <= r_h[1] + r_b + rot;
                    r_h[2] <= r_h[2] + r_b;
                    r_h[3] <= r_h[3] + r_c;
                    // length block done: present digest
                    if (r_final) begin
                        r_ovalid <= 1'b1;
                        r_widx   <= '0;
                    end
                end
            end
            if (r_state == ST_EMIT && !i_stall) begin
                r_widx <= r_widx + 1'b1;
                if (r_widx == 2'd3) begin
                    r_ovalid <= 1'b0;
                    r_h[0] <= IV0; r_h[1] <= IV1; r_h[2] <= IV2; r_h[3] <= IV3;
                    r_len  <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_final <= 1'b0;
        else if (start_comp && r_state == ST_LEN) r_final <= 1'b1;
        else if (r_state == ST_COMP && r_round == 6'd63) r_final <= 1'b0;
    end

    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> r_ovalid) else $error("emit without valid");
    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> (r_state == ST_IDLE)) else $error("pop while busy");
    a_final_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COMP && r_round == 6'd63 && r_final) |=> (r_state == ST_EMIT))
        else $error("digest not emitted");
endmodule

>>> design/md5_digest_stream.sv
// Top level of the MD5 stream digest.
// An accepted byte waits in the queue until the idle core pops it into the block buffer.
// Filling a block starts the single round unit; the core pops no byte until it is done.
// A finish writes pad and length bytes; digest word 0 is valid once the last block is done.
// Synchronous active-low reset restores the initial chaining words and clears the length.
module md5_digest_stream #(
    parameter int QUEUE_DEPTH = md5_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_mode,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [1:0]  o_word_index,
    output logic        o_last_word
);
    import md5_pkg::*;

    logic  q_valid, q_pop;
    t_item q_item;

    md5_front #(.DEPTH(QUEUE_DEPTH)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_mode, .i_data_byte,
        .o_q_valid(q_valid), .o_q_item(q_item), .i_q_pop(q_pop)
    );

    md5_core u_core (
        .i_clk, .i_rst_n, .i_q_valid(q_valid), .i_q_item(q_item), .o_q_pop(q_pop),
        .o_valid, .i_stall, .o_digest_word, .o_word_index, .o_last_word
    );
endmodule
